/* src/drrip_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_pkg
// shared constants and types for the drrip cache lookup block
// ----------------------------------------------------------------------------
package drrip_pkg;
	localparam int unsigned NUM_SETS_DEF       = 256;
	localparam int unsigned WAYS_DEF           = 8;
	localparam int unsigned LEADER_SETS_DEF    = 32;
	localparam int unsigned BIMODAL_PERIOD_DEF = 32;
	localparam int unsigned SELECTOR_BITS_DEF  = 10;

	localparam logic [1:0] RRPV_DISTANT = 2'd3;
	localparam logic [1:0] RRPV_LONG    = 2'd2;

	localparam logic REG_OFFSET_BITS = 1'b0;
	localparam logic REG_INDEX_BITS  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch request address
		logic rd_set;    // issue set read
		logic update;    // compute and write back the set
	} drrip_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_pending;
		logic clr_busy;    // valid ram clearing pass after reset
	} drrip_sts_t;
endpackage
`default_nettype wire

/* src/drrip_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ram
// generic simple dual port ram (one write, one read port), registered read
// ----------------------------------------------------------------------------
module drrip_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/drrip_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_dp
// datapath: set memories, tag compare, victim choice, policy counters
// ----------------------------------------------------------------------------
module drrip_dp #(
	parameter int unsigned NUM_SETS       = drrip_pkg::NUM_SETS_DEF,
	parameter int unsigned WAYS           = drrip_pkg::WAYS_DEF,
	parameter int unsigned LEADER_SETS    = drrip_pkg::LEADER_SETS_DEF,
	parameter int unsigned BIMODAL_PERIOD = drrip_pkg::BIMODAL_PERIOD_DEF,
	parameter int unsigned SELECTOR_BITS  = drrip_pkg::SELECTOR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire drrip_pkg::drrip_cmd_t cmd,
	output drrip_pkg::drrip_sts_t     sts,
	input  wire logic [31:0]          address,
	input  wire logic [3:0]           offset_bits,
	input  wire logic [3:0]           index_bits,
	output logic                      res_hit,
	output logic [2:0]                res_way,
	output logic                      res_filled_empty
);
	import drrip_pkg::*;

	localparam int unsigned SET_W = $clog2(NUM_SETS);
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned BC_W  = $clog2(BIMODAL_PERIOD + 1);
	// floor of log2 of the set count
	localparam logic [3:0]  MAX_IB = 4'($clog2(NUM_SETS + 1) - 1);
	localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
	localparam logic [SELECTOR_BITS-1:0] SEL_TOP = '1;

	logic [31:0]      tag_q;
	logic [SET_W-1:0] set_q;
	logic [SET_W-1:0] set_c;
	logic [31:0]      tag_c;
	logic [3:0]       ib;
	logic             rd_q;

	logic [32*WAYS-1:0] tag_rd;
	logic [2*WAYS-1:0]  rrpv_rd;
	logic [2*WAYS-1:0]  rrpv_raw;
	logic [WAYS-1:0]    vld_rd;
	logic [WAYS-1:0]    vld_new;
	logic [WAYS-1:0]    vld_wdata;
	logic [SET_W-1:0]   vld_waddr;
	logic               vld_we;

	logic [SET_W-1:0] clr_addr_q;
	logic             clr_busy_q;

	logic [SELECTOR_BITS-1:0] psel_q;
	logic [BC_W-1:0]          bc_q;

	assign ib = (index_bits > MAX_IB) ? MAX_IB : index_bits;
	assign set_c = SET_W'((address >> offset_bits) & ((32'd1 << ib) - 32'd1));
	assign tag_c = address >> ({1'b0, offset_bits} + {1'b0, ib});
	assign sts.rd_pending = rd_q;
	assign sts.clr_busy   = clr_busy_q;

	// update logic
	logic [WAYS-1:0]    hitv, freev;
	logic [WAY_W-1:0]   hit_w, free_w, vic_w, sel_w;
	logic               any_hit, any_free, srrip, lead_s, lead_b;
	logic [1:0]         oldest, step, ins;
	logic [2*WAYS-1:0]  aged, rrpv_new;
	logic [32*WAYS-1:0] tag_new;
	logic [BC_W-1:0]    bc_next;
	logic               bc_wrap;

	always_comb begin
		hit_w = '0; free_w = '0; vic_w = '0;
		any_hit = 1'b0; any_free = 1'b0; oldest = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hitv[w]  = vld_rd[w] && (tag_rd[32*w +: 32] == tag_q);
			freev[w] = !vld_rd[w];
			if (hitv[w]) begin hit_w = WAY_W'(w); any_hit = 1'b1; end
			if (freev[w]) begin free_w = WAY_W'(w); any_free = 1'b1; end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (rrpv_rd[2*w +: 2] > oldest) oldest = rrpv_rd[2*w +: 2];
		end
		step = RRPV_DISTANT - oldest;
		for (int w = 0; w < WAYS; w++) begin
			aged[2*w +: 2] = rrpv_rd[2*w +: 2] + step;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (aged[2*w +: 2] == RRPV_DISTANT) vic_w = WAY_W'(w);
		end
		lead_s = 32'(set_q) < LEADER_SETS;
		lead_b = !lead_s && (32'(set_q) < 2 * LEADER_SETS);
		srrip  = lead_s || (!lead_b && psel_q >= SEL_MID);
		bc_next = bc_q + 1'b1;
		bc_wrap = 32'(bc_next) >= BIMODAL_PERIOD;
		ins = (srrip || bc_wrap) ? RRPV_LONG : RRPV_DISTANT;
		sel_w = any_hit ? hit_w : (any_free ? free_w : vic_w);
		rrpv_new = (any_hit || any_free) ? rrpv_rd : aged;
		rrpv_new[2*sel_w +: 2] = any_hit ? 2'd0 : ins;
		tag_new = tag_rd;
		tag_new[32*sel_w +: 32] = tag_q;
		vld_new = vld_rd;
		vld_new[sel_w] = 1'b1;
	end

	logic wr;
	assign wr = cmd.update;

	// clearing pass owns the valid ram write port until it ends
	assign vld_we    = clr_busy_q || (wr && !any_hit);
	assign vld_waddr = clr_busy_q ? clr_addr_q : set_q;
	assign vld_wdata = clr_busy_q ? '0 : vld_new;

	drrip_ram #(.WIDTH(32*WAYS), .DEPTH(NUM_SETS)) u_tag (
		.clk(clk), .we(wr && !any_hit), .waddr(set_q), .wdata(tag_new),
		.raddr(set_c), .rdata(tag_rd)
	);
	drrip_ram #(.WIDTH(2*WAYS), .DEPTH(NUM_SETS)) u_rrpv (
		.clk(clk), .we(wr), .waddr(set_q), .wdata(rrpv_new ^ {WAYS{2'b11}}),
		.raddr(set_c), .rdata(rrpv_raw)
	);
	drrip_ram #(.WIDTH(WAYS), .DEPTH(NUM_SETS)) u_vld (
		.clk(clk), .we(vld_we), .waddr(vld_waddr), .wdata(vld_wdata),
		.raddr(set_c), .rdata(vld_rd)
	);
	// rrpv stored inverted; an invalid way reads as rrpv 3 through its valid bit
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rrpv_rd[2*w +: 2] = vld_rd[w] ? ~rrpv_raw[2*w +: 2] : RRPV_DISTANT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			psel_q <= SEL_MID;
			bc_q <= '0;
			rd_q <= 1'b0;
		end else begin
			rd_q <= cmd.rd_set;
			if (clr_busy_q) begin
				if (clr_addr_q == SET_W'(NUM_SETS - 1)) clr_busy_q <= 1'b0;
				else clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (wr && !any_hit) begin
				if (!srrip) bc_q <= bc_wrap ? '0 : bc_next;
				if (!any_free && lead_s && psel_q != '0) psel_q <= psel_q - 1'b1;
				if (!any_free && lead_b && psel_q != SEL_TOP) psel_q <= psel_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q <= tag_c;
			set_q <= set_c;
		end
		if (wr) begin
			res_hit <= any_hit;
			res_way <= 3'(32'(sel_w));
			res_filled_empty <= !any_hit && any_free;
		end
	end
endmodule
`default_nettype wire

/* src/drrip_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ctrl
// controller: request accept, set read, update, result handshake
// ----------------------------------------------------------------------------
module drrip_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output drrip_pkg::drrip_cmd_t      cmd,
	input  wire drrip_pkg::drrip_sts_t sts
);
	import drrip_pkg::*;

	typedef enum logic [0:0] {ST_IDLE, ST_UPD} state_t;
	state_t state_q;
	logic   acc;

	// accept when idle, cleared, and the result slot is free or draining
	assign in_ready = (state_q == ST_IDLE) && !sts.clr_busy && (!out_valid || out_ready);
	assign acc = in_valid && in_ready;
	assign cmd.capture = acc;
	assign cmd.rd_set  = acc;
	assign cmd.update  = (state_q == ST_UPD) && sts.rd_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid && out_ready) out_valid <= 1'b0;
					if (acc) state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/drrip_set_assoc_cache_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_set_assoc_cache_lookup
// set associative tag lookup with drrip replacement
// ----------------------------------------------------------------------------
// usage:
//   request channel: address with in_valid / in_ready
//   result channel: hit, way, filled_empty with out_valid / out_ready
//   config port: cfg_we, cfg_index, cfg_data; write only while idle
// timing:
//   a request is accepted and the set (tags, rrpv, valid) is read from
//   synchronous ram; the registered read data is compared, updated and
//   written back, and the result is registered with out_valid set
//   a new request is not accepted until the set has been written back
// reset:
//   a clearing pass zeroes the valid ram one set per cycle over all NUM_SETS
//   sets (256 by default), with in_ready held low until it ends;
//   an invalid way reads as rrpv 3; selector to midpoint, bimodal count 0
// stall:
//   the result stays in its output register until taken; the next request
//   is accepted in the same cycle the previous result is taken
// ----------------------------------------------------------------------------
module drrip_set_assoc_cache_lookup #(
	parameter int unsigned NUM_SETS       = drrip_pkg::NUM_SETS_DEF,
	parameter int unsigned WAYS           = drrip_pkg::WAYS_DEF,
	parameter int unsigned LEADER_SETS    = drrip_pkg::LEADER_SETS_DEF,
	parameter int unsigned BIMODAL_PERIOD = drrip_pkg::BIMODAL_PERIOD_DEF,
	parameter int unsigned SELECTOR_BITS  = drrip_pkg::SELECTOR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [2:0]       way,
	output logic             filled_empty,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);
	import drrip_pkg::*;

	drrip_cmd_t cmd;
	drrip_sts_t sts;
	logic [3:0] offset_bits_q;
	logic [3:0] index_bits_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd6;
			index_bits_q  <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_INDEX_BITS:  index_bits_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	drrip_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	drrip_dp #(
		.NUM_SETS(NUM_SETS), .WAYS(WAYS), .LEADER_SETS(LEADER_SETS),
		.BIMODAL_PERIOD(BIMODAL_PERIOD), .SELECTOR_BITS(SELECTOR_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .address(address),
		.offset_bits(offset_bits_q), .index_bits(index_bits_q),
		.res_hit(hit), .res_way(way), .res_filled_empty(filled_empty)
	);
endmodule
`default_nettype wire

/* src/drrip_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_chk
// port level checks for the cache lookup block
// ----------------------------------------------------------------------------
module drrip_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       hit,
	input wire logic       filled_empty
);
	// an accepted request gives a result once its set has been read and updated
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid ##1 out_valid) else $error("latency");
	// no new request the cycle right after one
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("rate");
	// a hit never reports an empty fill
	a_fe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && filled_empty)) else $error("hit fill");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit)) else $error("hold");
endmodule

bind drrip_set_assoc_cache_lookup drrip_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .hit(hit),
	.filled_empty(filled_empty)
);
`default_nettype wire
